### rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; every other file of the block imports this package.
package ple_pkg;

  // Default list capacity and the index width that covers the full capacity range
  localparam int PLE_CAPACITY = 64;
  localparam int AT_W         = 11;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 16;
  localparam int CNT_OUT_W    = 7;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_NEG   = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // Operation broadcast to every cell of the row
  typedef enum logic [2:0] {
    CELL_HOLD     = 3'd0,
    CELL_INSERT   = 3'd1,
    CELL_DELETE   = 3'd2,
    CELL_RD_LOAD  = 3'd3,
    CELL_RD_SHIFT = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [AT_W-1:0]     at;
    logic [DATA_W-1:0]   data;
  } cell_ctl_t;

endpackage

### rtl/ple_cell.sv
// One list slot: holds the entry at its index plus one stage of the read column.
// Depends on ple_pkg for the cell control word.
module ple_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  ple_pkg::cell_ctl_t        ctl,
  input  logic [ple_pkg::DATA_W-1:0] lo_entry,
  input  logic [ple_pkg::DATA_W-1:0] hi_entry,
  input  logic [ple_pkg::DATA_W-1:0] hi_rd,
  output logic [ple_pkg::DATA_W-1:0] entry,
  output logic [ple_pkg::DATA_W-1:0] rd
);
  import ple_pkg::*;

  logic [AT_W-1:0] my_idx;

  assign my_idx = AT_W'(INDEX);

  // Entry: shift up on insert, down on delete, otherwise hold
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_INSERT: begin
        if (my_idx == ctl.at) begin
          entry <= ctl.data;
        end else if (my_idx > ctl.at) begin
          entry <= lo_entry;
        end
      end
      CELL_DELETE: begin
        if (my_idx >= ctl.at) begin
          entry <= hi_entry;
        end
      end
      default: begin
      end
    endcase
  end

  // Read column: parallel load, then move one slot toward index zero per cycle
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_RD_LOAD:  rd <= entry;
      CELL_RD_SHIFT: rd <= hi_rd;
      default: begin
      end
    endcase
  end

endmodule

### rtl/ple_ctrl.sv
// Command decoder, entry count and result register of the positional list engine.
// Depends on ple_pkg; drives the control word shared by all cells.
module ple_ctrl #(
  parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [1:0]                    command,
  input  logic [ple_pkg::POS_W-1:0]     position,
  input  logic [ple_pkg::DATA_W-1:0]    value,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ple_pkg::DATA_W-1:0]    read_value,
  output logic [1:0]                    status,
  output logic [ple_pkg::CNT_OUT_W-1:0] entry_count,
  input  logic [ple_pkg::DATA_W-1:0]    rd_head,
  output ple_pkg::cell_ctl_t            cell_ctl
);
  import ple_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > POS_W - 1) ? CW : POS_W - 1;

  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        rem, rem_next;
  logic                 load_out;
  logic [DATA_W-1:0]    rv_next;
  status_t              st_next;

  logic                 out_free;
  logic                 accept;
  logic                 pos_neg;
  logic [CMP_W-1:0]     pos_u;
  logic [CMP_W-1:0]     cnt_u;
  logic                 in_range;
  logic                 full;
  logic [CMP_W-1:0]     at_u;
  cmd_t                 cmd;

  // Position checks against the current count
  assign cmd      = cmd_t'(command);
  assign pos_neg  = position[POS_W-1];
  assign pos_u    = CMP_W'(position[POS_W-2:0]);
  assign cnt_u    = CMP_W'(count);
  assign in_range = !pos_neg && (pos_u < cnt_u);
  assign full     = (count == CW'(CAPACITY));
  assign at_u     = (pos_u > cnt_u) ? cnt_u : pos_u;
  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd == CMD_READ && in_range) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (rem == '0 && out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: cell control, count update, result word
  always_comb begin
    s_tready      = 1'b0;
    cell_ctl.op   = CELL_HOLD;
    cell_ctl.at   = AT_W'(at_u);
    cell_ctl.data = value;
    count_next    = count;
    rem_next      = rem;
    load_out      = 1'b0;
    rv_next       = '0;
    st_next       = ST_DONE;
    unique case (state)
      S_IDLE: begin
        s_tready = out_free;
        if (accept) begin
          load_out = 1'b1;
          unique case (cmd)
            CMD_INSERT: begin
              if (pos_neg) begin
                st_next = ST_NEG;
              end else if (full) begin
                st_next = ST_FULL;
              end else begin
                cell_ctl.op = CELL_INSERT;
                count_next  = count + 1'b1;
              end
            end
            CMD_READ: begin
              if (!in_range) begin
                st_next = ST_RANGE;
              end else begin
                cell_ctl.op = CELL_RD_LOAD;
                rem_next    = CW'(pos_u);
                load_out    = 1'b0;
              end
            end
            CMD_DELETE: begin
              if (!in_range) begin
                st_next = ST_RANGE;
              end else begin
                cell_ctl.op = CELL_DELETE;
                cell_ctl.at = AT_W'(pos_u);
                count_next  = count - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (rem == '0) begin
          if (out_free) begin
            load_out = 1'b1;
            rv_next  = rd_head;
          end
        end else begin
          cell_ctl.op = CELL_RD_SHIFT;
          rem_next    = rem - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rem      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rem   <= rem_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (load_out) begin
      read_value  <= rv_next;
      status      <= st_next;
      entry_count <= CNT_OUT_W'(count_next);
    end
  end

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_INSERT && !pos_neg && !full |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the list");

  a_read_enters: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_READ && in_range |=> state == S_READ && !m_tvalid)
    else $error("in-range read did not start the read sweep");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !s_tready)
    else $error("input taken during a read sweep");

endmodule

### rtl/positional_list_engine_top.sv
// Top level of the positional list engine: the row of list cells and the controller.
// Depends on ple_pkg, ple_cell and ple_ctrl.
//
// An ordered list of signed 32-bit words, one word per cell, CAPACITY cells in a
// row. Insert, delete and every rejected command complete at the accepting edge:
// all cells shift or hold at once and the result word is registered at that edge.
// A read loads every entry into a column of registers that moves one cell toward
// index zero per cycle until entry p reaches index zero; one item is in work at a
// time. The list needs no clearing after reset. An input word is taken whenever
// the block is idle and the result register is empty or being drained.
module positional_list_engine_top #(
  parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // command[1:0], position[17:2], value[49:18], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // read_value[31:0], status[33:32], entry_count[40:34], pad
);
  import ple_pkg::*;

  cell_ctl_t             cell_ctl;
  logic [DATA_W-1:0]     entry [CAPACITY];
  logic [DATA_W-1:0]     rd    [CAPACITY];
  logic [DATA_W-1:0]     read_value;
  logic [1:0]            status;
  logic [CNT_OUT_W-1:0]  entry_count;

  // Controller
  ple_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .command     (s_tdata[1:0]),
    .position    (s_tdata[17:2]),
    .value       (s_tdata[49:18]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count),
    .rd_head     (rd[0]),
    .cell_ctl    (cell_ctl)
  );

  // Row of cells, each wired to both neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] lo_entry;
    logic [DATA_W-1:0] hi_entry;
    logic [DATA_W-1:0] hi_rd;

    if (g == 0) begin : g_lo_end
      assign lo_entry = '0;
    end else begin : g_lo_mid
      assign lo_entry = entry[g-1];
    end

    if (g == CAPACITY - 1) begin : g_hi_end
      assign hi_entry = '0;
      assign hi_rd    = '0;
    end else begin : g_hi_mid
      assign hi_entry = entry[g+1];
      assign hi_rd    = rd[g+1];
    end

    ple_cell #(
      .INDEX (g)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .lo_entry (lo_entry),
      .hi_entry (hi_entry),
      .hi_rd    (hi_rd),
      .entry    (entry[g]),
      .rd       (rd[g])
    );
  end

  // Result word packing
  assign m_tdata = {7'd0, entry_count, status, read_value};

endmodule

### bench/ple_list_checker.sv
// Checker for the positional list engine: watches both stream channels, keeps a
// shadow copy of the list, predicts each result word and compares it field by field.
// Depends on ple_pkg.
module ple_list_checker #(
  parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // command[1:0], position[17:2], value[49:18], zero pad
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // read_value[31:0], status[33:32], entry_count[40:34], pad
  output int          errors,
  output int          pending,
  output int          list_len,
  output int          results_seen,
  output int          reads_done,
  output int          full_hits,
  output int          peak_len
);
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  // Result word layout, read_value in the low bits
  typedef struct packed {
    logic [6:0]  entry_count;
    status_t     status;
    logic [31:0] read_value;
  } list_result_t;

  logic [31:0]  shadow_list[$];
  list_result_t pending_results[$];

  initial begin
    errors = 0;
    pending = 0;
    list_len = 0;
    results_seen = 0;
    reads_done = 0;
    full_hits = 0;
    peak_len = 0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 30) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Apply one command to the shadow list and return the result word it yields
  function automatic list_result_t apply_list_command(input logic [1:0] cmd,
                                                      input logic [15:0] pos_raw,
                                                      input logic [31:0] val);
    list_result_t res;
    int           p;
    int           len;
    int           at;
    p   = int'($signed(pos_raw));
    len = shadow_list.size();
    res.read_value = '0;
    res.status     = ST_DONE;
    case (cmd)
      CMD_INSERT: begin
        if (p < 0) begin
          res.status = ST_NEG;
        end else if (len >= CAPACITY) begin
          res.status = ST_FULL;
          full_hits++;
        end else begin
          at = (p > len) ? len : p;
          shadow_list.insert(at, val);
        end
      end
      CMD_READ, CMD_DELETE: begin
        if (p < 0 || p >= len) begin
          res.status = ST_RANGE;
        end else if (cmd == CMD_READ) begin
          res.read_value = shadow_list[p];
          reads_done++;
        end else begin
          shadow_list.delete(p);
        end
      end
      default: ;  // unused code: no change
    endcase
    len = shadow_list.size();
    res.entry_count = 7'(len);
    if (len > peak_len) peak_len = len;
    return res;
  endfunction

  // Result side first: a word taken at this edge cannot answer one sent at the same edge
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst) begin
      shadow_list.delete();
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[40:0];
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing outstanding", m_tdata));
        end else begin
          want = pending_results.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch($sformatf("word %0d read_value %h, want %h",
                                      results_seen, got.read_value, want.read_value));
          if (got.status !== want.status)
            report_mismatch($sformatf("word %0d status %0d, want %0d",
                                      results_seen, got.status, want.status));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("word %0d entry_count %0d, want %0d",
                                      results_seen, got.entry_count, want.entry_count));
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(apply_list_command(s_tdata[1:0], s_tdata[17:2],
                                                     s_tdata[49:18]));
    end
    pending  = pending_results.size();
    list_len = shadow_list.size();
  end

endmodule

### bench/positional_list_engine_top_tb.sv
// Testbench top for the positional list engine: clock, reset, command stimulus
// with bursty sending and a stalling receiver, and the final verdict.
// Depends on ple_pkg, positional_list_engine_top and ple_list_checker.
module positional_list_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  localparam int         CAP        = PLE_CAPACITY;
  localparam int         RAND_WORDS = 1400;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {SEG_GROW, SEG_SHRINK, SEG_MIXED, SEG_NOISE} segment_t;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  int errors, pending, list_len, results_seen, reads_done, full_hits, peak_len;
  int burst_left = 0;
  int words_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_engine_top #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ple_list_checker #(.CAPACITY(CAP)) u_list_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .errors       (errors),
    .pending      (pending),
    .list_len     (list_len),
    .results_seen (results_seen),
    .reads_done   (reads_done),
    .full_hits    (full_hits),
    .peak_len     (peak_len)
  );

  // Send one command word; a new burst starts with a random idle gap
  task automatic send_word(input logic [1:0] cmd, input logic [15:0] pos,
                           input logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, val, pos, cmd};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Stop sending until every outstanding result has come back
  task automatic hold_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  // One random command word shaped by the current segment
  task automatic random_word(input segment_t seg);
    int          len;
    int          roll;
    logic [1:0]  cmd;
    logic [15:0] pos;
    logic [31:0] val;
    len  = list_len;
    roll = $urandom_range(0, 99);
    case (seg)
      SEG_GROW:   cmd = (roll < 80) ? CMD_INSERT : (roll < 90) ? CMD_READ :
                        (roll < 98) ? CMD_DELETE : CMD_UNUSED;
      SEG_SHRINK: cmd = (roll < 20) ? CMD_INSERT : (roll < 45) ? CMD_READ :
                        (roll < 98) ? CMD_DELETE : CMD_UNUSED;
      SEG_MIXED:  cmd = (roll < 35) ? CMD_INSERT : (roll < 70) ? CMD_READ :
                        (roll < 97) ? CMD_DELETE : CMD_UNUSED;
      default:    cmd = (roll < 30) ? CMD_INSERT : (roll < 55) ? CMD_READ :
                        (roll < 80) ? CMD_DELETE : CMD_UNUSED;
    endcase
    roll = (seg == SEG_NOISE) ? 88 : $urandom_range(0, 99);
    if (roll < 75) begin
      if (cmd == CMD_INSERT) pos = 16'($urandom_range(0, len + 1));
      else pos = (len > 0) ? 16'($urandom_range(0, len - 1)) : 16'd0;
    end else if (roll < 85) begin
      pos = 16'($urandom_range(len, len + 3));
    end else if (roll < 93) begin
      pos = 16'($urandom());
    end else begin
      case ($urandom_range(0, 3))
        0:       pos = 16'h7FFF;
        1:       pos = 16'h8000;
        2:       pos = 16'hFFFF;
        default: pos = 16'h0000;
      endcase
    end
    if ($urandom_range(0, 9) != 0) val = $urandom();
    else val = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_word(cmd, pos, val);
  endtask

  // Receiver back-pressure: runs of open, random, sparse and toggling ready
  initial begin
    rx_mode_t mode;
    int       span;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 5) == 0);
          default:   m_tready <= ~m_tready;
        endcase
      end
    end
  end

  // Run limit
  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    segment_t seg;
    int       seg_len;
    int       sent_random;
    int       w;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty list, negative inserts, unused code, edge positions and values
    send_word(CMD_READ,   16'd0,      32'h1234_5678);
    send_word(CMD_DELETE, 16'd0,      32'h0);
    send_word(CMD_INSERT, 16'hFFFF,   32'h1111_1111);
    send_word(CMD_INSERT, 16'h8000,   32'h2222_2222);
    send_word(CMD_UNUSED, 16'd0,      32'hFFFF_FFFF);
    send_word(CMD_INSERT, 16'h7FFF,   32'h7FFF_FFFF);  // append to empty list
    send_word(CMD_INSERT, 16'd0,      32'h8000_0000);  // front
    send_word(CMD_INSERT, 16'd1,      32'h0000_0000);  // middle
    send_word(CMD_INSERT, 16'd3,      32'hFFFF_FFFF);  // exactly at count
    send_word(CMD_READ,   16'd0,      32'h0);
    send_word(CMD_READ,   16'd1,      32'h0);
    send_word(CMD_READ,   16'd2,      32'h0);
    send_word(CMD_READ,   16'd3,      32'h0);
    send_word(CMD_READ,   16'd4,      32'h0);          // one past the end
    send_word(CMD_READ,   16'hFFFF,   32'h0);
    send_word(CMD_READ,   16'h7FFF,   32'h0);
    send_word(CMD_DELETE, 16'hFFFF,   32'h0);
    send_word(CMD_DELETE, 16'd4,      32'h0);
    send_word(CMD_UNUSED, 16'hFFFF,   32'h0);          // unused code on a filled list
    send_word(CMD_DELETE, 16'd1,      32'h0);          // middle
    send_word(CMD_DELETE, 16'd2,      32'h0);          // last
    send_word(CMD_DELETE, 16'd0,      32'h0);          // front
    send_word(CMD_READ,   16'd0,      32'h0);
    hold_until_drained();

    // Random segments; the first one is insert-heavy, driving the list toward full so full rejects can show up early
    sent_random = 0;
    seg = SEG_GROW;
    while (sent_random < RAND_WORDS) begin
      seg_len = $urandom_range(60, 160);
      repeat (seg_len) random_word(seg);
      sent_random += seg_len;
      hold_until_drained();
      seg = segment_t'($urandom_range(0, 3));
    end

    // Let any stray result show up before the verdict
    w = 0;
    while (pending != 0 && w < 100000) begin
      @(negedge clk);
      w++;
    end
    repeat (100) @(negedge clk);

    $display("Sent %0d command words, checked %0d results: %0d good reads, %0d full rejects,",
             words_sent, results_seen, reads_done, full_hits);
    $display("list length peaked at %0d of %0d entries.", peak_len, CAP);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
